// ----- hdl/fbv_pkg.sv -----
// Shared constants and codes for the frustum box visibility block.
// No dependencies; every other file in hdl/ refers to this package by scoped name.
`default_nettype none

package fbv_pkg;

  localparam int unsigned DefValueBits = 24;
  localparam int unsigned NumPlanes    = 6;
  localparam int unsigned NumCoeffs    = 4;
  localparam int unsigned NumAxes      = 3;
  localparam int unsigned NumRows      = 4;
  localparam int unsigned CoeffOffset  = 3;
  localparam int unsigned RowW         = 3;
  localparam int unsigned VertexShift  = 8;

  typedef enum logic {
    ActLoad = 1'b0,
    ActTest = 1'b1
  } action_e;

endpackage

`default_nettype wire

// ----- hdl/fbv_plane_store.sv -----
// Plane coefficient registers: six planes by four coefficients, built from matrix columns.
// Depends on fbv_pkg for plane and coefficient counts.
`default_nettype none

module fbv_plane_store #(
  parameter int unsigned ValueBits = fbv_pkg::DefValueBits
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   load_i,
  input  wire logic [1:0]                             column_i,
  input  wire logic [fbv_pkg::NumRows-1:0][ValueBits-1:0] rows_i,
  output logic [fbv_pkg::NumPlanes-1:0][fbv_pkg::NumCoeffs-1:0][ValueBits:0] coeffs_o
);

  logic [fbv_pkg::NumPlanes-1:0][ValueBits:0]                        col_d;
  logic [fbv_pkg::NumPlanes-1:0][fbv_pkg::NumCoeffs-1:0][ValueBits:0] coeff_q;

  for (genvar j = 0; j < fbv_pkg::NumAxes; j++) begin : g_row
    logic signed [ValueBits:0] w_row;
    logic signed [ValueBits:0] ref_row;
    assign w_row   = $signed({rows_i[fbv_pkg::RowW][ValueBits-1],
                              rows_i[fbv_pkg::RowW]});
    assign ref_row = $signed({rows_i[j][ValueBits-1], rows_i[j]});
    assign col_d[2*j]   = w_row + ref_row;
    assign col_d[2*j+1] = w_row - ref_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
    end else if (load_i) begin
      for (int p = 0; p < fbv_pkg::NumPlanes; p++) begin
        coeff_q[p][column_i] <= col_d[p];
      end
    end
  end

  assign coeffs_o = coeff_q;

endmodule

`default_nettype wire

// ----- hdl/fbv_vertex_mult.sv -----
// Positive-vertex selection and per-plane products, registered as summands.
// Depends on fbv_pkg for plane, axis and shift constants.
`default_nettype none

module fbv_vertex_mult #(
  parameter int unsigned ValueBits = fbv_pkg::DefValueBits,
  localparam int unsigned SumW     = 2 * ValueBits + 3
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   capture_i,
  input  wire logic [fbv_pkg::NumPlanes-1:0][fbv_pkg::NumCoeffs-1:0][ValueBits:0] coeffs_i,
  input  wire logic [fbv_pkg::NumAxes-1:0][ValueBits-1:0] box_min_i,
  input  wire logic [fbv_pkg::NumAxes-1:0][ValueBits-1:0] box_max_i,
  output logic [fbv_pkg::NumPlanes-1:0][fbv_pkg::NumCoeffs-1:0][SumW-1:0] terms_o
);

  localparam int unsigned ProdW = 2 * ValueBits + 1;
  localparam int unsigned ExtW  = SumW - ProdW;
  localparam int unsigned OffW  = SumW - ValueBits - 1 - fbv_pkg::VertexShift;

  logic [fbv_pkg::NumPlanes-1:0][fbv_pkg::NumCoeffs-1:0][SumW-1:0] term_d;
  logic [fbv_pkg::NumPlanes-1:0][fbv_pkg::NumCoeffs-1:0][SumW-1:0] term_q;

  for (genvar p = 0; p < fbv_pkg::NumPlanes; p++) begin : g_plane
    for (genvar k = 0; k < fbv_pkg::NumAxes; k++) begin : g_axis
      logic signed [ValueBits:0]   norm;
      logic signed [ValueBits-1:0] vert;
      logic signed [ProdW-1:0]     prod;
      assign norm = $signed(coeffs_i[p][k]);
      assign vert = norm[ValueBits] ? $signed(box_min_i[k]) : $signed(box_max_i[k]);
      assign prod = norm * vert;
      assign term_d[p][k] = {{ExtW{prod[ProdW-1]}}, prod};
    end
    logic [ValueBits:0] offs;
    assign offs = coeffs_i[p][fbv_pkg::CoeffOffset];
    assign term_d[p][fbv_pkg::CoeffOffset] =
      {{OffW{offs[ValueBits]}}, offs, {fbv_pkg::VertexShift{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      term_q <= term_d;
    end
  end

  assign terms_o = term_q;

endmodule

`default_nettype wire

// ----- hdl/fbv_sign_stage.sv -----
// Plane sums, sign test and the registered visibility flag.
// Depends on fbv_pkg for plane and coefficient counts.
`default_nettype none

module fbv_sign_stage #(
  parameter int unsigned ValueBits = fbv_pkg::DefValueBits,
  localparam int unsigned SumW     = 2 * ValueBits + 3
) (
  input  wire logic clk_i,
  input  wire logic commit_i,
  input  wire logic [fbv_pkg::NumPlanes-1:0][fbv_pkg::NumCoeffs-1:0][SumW-1:0] terms_i,
  output logic      visible_o
);

  logic [fbv_pkg::NumPlanes-1:0] behind;
  logic                          visible_d;
  logic                          visible_q;

  for (genvar p = 0; p < fbv_pkg::NumPlanes; p++) begin : g_plane
    logic signed [SumW-1:0] sum;
    assign sum = $signed(terms_i[p][0]) + $signed(terms_i[p][1])
               + $signed(terms_i[p][2]) + $signed(terms_i[p][3]);
    assign behind[p] = sum[SumW-1];
  end

  assign visible_d = ~|behind;

  always_ff @(posedge clk_i) begin
    if (commit_i) begin
      visible_q <= visible_d;
    end
  end

  assign visible_o = visible_q;

endmodule

`default_nettype wire

// ----- hdl/frustum_box_visibility.sv -----
// Frustum box visibility: plane store, vertex products and sign stage under a two-slot pipe.
// Depends on fbv_pkg, fbv_plane_store, fbv_vertex_mult and fbv_sign_stage.
//
//   channel  handshake                  payload
//   in       in_valid_i / in_ready_o    action_i, column_index_i, elem_row0..3_i, min/max_*_i
//   out      out_valid_o / out_ready_i  visible_o (one per test request, none per load)
//
// A request is taken every cycle while in_ready_o is high; a test result passes through the
// product register and the result register and is held on visible_o until it is taken.
// Load requests update the plane registers at the accepting edge and give no result.
// Throughput is set by the product register and the result register, one slot each.
// Reset clears the plane coefficients to zero, so boxes read as visible before any load.
// A stalled result holds; the product slot keeps taking requests while it can move on.
`default_nettype none

module frustum_box_visibility #(
  parameter int unsigned ValueBits = fbv_pkg::DefValueBits
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 action_i,
  input  wire logic [1:0]           column_index_i,
  input  wire logic [ValueBits-1:0] elem_row0_i,
  input  wire logic [ValueBits-1:0] elem_row1_i,
  input  wire logic [ValueBits-1:0] elem_row2_i,
  input  wire logic [ValueBits-1:0] elem_row3_i,
  input  wire logic [ValueBits-1:0] min_x_i,
  input  wire logic [ValueBits-1:0] min_y_i,
  input  wire logic [ValueBits-1:0] min_z_i,
  input  wire logic [ValueBits-1:0] max_x_i,
  input  wire logic [ValueBits-1:0] max_y_i,
  input  wire logic [ValueBits-1:0] max_z_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      visible_o
);

  localparam int unsigned SumW = 2 * ValueBits + 3;

  logic accept;
  logic load;
  logic capture;
  logic commit;
  logic out_free;
  logic s1_valid_d, s1_valid_q;
  logic out_valid_d, out_valid_q;

  logic [fbv_pkg::NumRows-1:0][ValueBits-1:0]  rows;
  logic [fbv_pkg::NumAxes-1:0][ValueBits-1:0]  box_min;
  logic [fbv_pkg::NumAxes-1:0][ValueBits-1:0]  box_max;
  logic [fbv_pkg::NumPlanes-1:0][fbv_pkg::NumCoeffs-1:0][ValueBits:0] coeffs;
  logic [fbv_pkg::NumPlanes-1:0][fbv_pkg::NumCoeffs-1:0][SumW-1:0]    terms;

  assign rows    = {elem_row3_i, elem_row2_i, elem_row1_i, elem_row0_i};
  assign box_min = {min_z_i, min_y_i, min_x_i};
  assign box_max = {max_z_i, max_y_i, max_x_i};

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign load       = accept && (fbv_pkg::action_e'(action_i) == fbv_pkg::ActLoad);
  assign capture    = accept && (fbv_pkg::action_e'(action_i) == fbv_pkg::ActTest);
  assign commit     = s1_valid_q && out_free;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (capture) begin
      s1_valid_d = 1'b1;
    end else if (out_free) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  fbv_plane_store #(
    .ValueBits(ValueBits)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .column_i(column_index_i),
    .rows_i  (rows),
    .coeffs_o(coeffs)
  );

  fbv_vertex_mult #(
    .ValueBits(ValueBits)
  ) u_mult (
    .clk_i    (clk_i),
    .capture_i(capture),
    .coeffs_i (coeffs),
    .box_min_i(box_min),
    .box_max_i(box_max),
    .terms_o  (terms)
  );

  fbv_sign_stage #(
    .ValueBits(ValueBits)
  ) u_sign (
    .clk_i    (clk_i),
    .commit_i (commit),
    .terms_i  (terms),
    .visible_o(visible_o)
  );

  a_test_fills_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture |=> s1_valid_q)
    else $error("accepted test request did not occupy the product slot");

  a_slot_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q)
    else $error("product slot dropped a request while the result stalled");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input ready while both slots are full and stalled");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_valid_q))
    else $error("result appeared without a request in the product slot");

endmodule

`default_nettype wire
